### sv/cpl_pkg.sv
// Package: request and result types, mode and status codes for the compacting list.
`timescale 1ns / 1ps
package cpl_pkg;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_GET    = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam int GROUP_SIZE = 32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  index;
    logic [63:0] value;
  } in_req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [1:0]  status;
    logic [9:0]  length;
  } out_res_t;

  typedef struct packed {
    logic append_go;
    logic remove_go;
    logic get_go;
  } cell_ctrl_t;

endpackage

### sv/compacting_pointer_list.sv
// Top level: fixed-capacity compacting list built as a row of entry cells.
//
//   channel  ports                    handshake
//   request  start, busy, in_req      taken at a clock edge with start high, busy low
//   result   out_valid, out_res       out_valid high for one cycle, no back-pressure
//
// On each request the accept edge updates the cell row and captures the
// per-group read-out, and the next edge folds the groups into the result
// register. busy is high for the one cycle in between, so no new request is
// taken while the last one is folded. A remove shifts all later cells at once.
// rst_n (synchronous) clears the count and the control flags; cell contents
// are not reset. The result side cannot stall.
`timescale 1ns / 1ps
module compacting_pointer_list #(
  parameter int CAPACITY = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cpl_pkg::in_req_t  in_req,
  output logic              out_valid,
  output cpl_pkg::out_res_t out_res
);
  import cpl_pkg::*;

  // count width holds CAPACITY itself; compare width covers count and index
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (CW > 9) ? CW : 9;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          s1_r;
  logic          get_r;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic [9:0]    length_r;
  logic          out_valid_r;
  out_res_t      out_res_r;

  logic          accept;
  logic          full;
  logic          in_range;
  logic [KW-1:0] idx_ext;
  logic [KW-1:0] cnt_ext;
  logic [CW+9:0] len_wide;
  cell_ctrl_t    ctrl;
  logic [63:0]   cell_q  [CAPACITY];
  logic [63:0]   cell_rd [CAPACITY];
  logic [63:0]   read_sum;

  assign accept   = start && !busy;
  assign busy     = s1_r;
  assign idx_ext  = KW'(in_req.index);
  assign cnt_ext  = KW'(count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign in_range = (idx_ext < cnt_ext);

  // Broadcast the decoded request to every cell
  assign ctrl.append_go = accept && (in_req.mode == MODE_APPEND) && !full;
  assign ctrl.remove_go = accept && (in_req.mode == MODE_REMOVE) && in_range;
  assign ctrl.get_go    = accept && (in_req.mode == MODE_GET) && in_range;

  always_comb begin
    status_nxt = STATUS_OK;
    case (in_req.mode)
      MODE_APPEND: if (full) status_nxt = STATUS_FULL;
      MODE_REMOVE: if (!in_range) status_nxt = STATUS_RANGE;
      MODE_GET:    if (!in_range) status_nxt = STATUS_RANGE;
      default:     status_nxt = STATUS_OK;   // unused mode: no change
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.append_go) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.remove_go) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Report length masked to its 10-bit field
  assign len_wide = {10'd0, count_nxt};

  // Row of cells; on a remove, each cell from the index up to below the last entry takes its upper neighbor's entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [63:0] nbr;
    if (i + 1 < CAPACITY) begin : g_mid
      assign nbr = cell_q[i + 1];
    end else begin : g_last
      assign nbr = 64'd0;
    end
    cpl_cell #(
      .POS (i),
      .KW  (KW)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .idx    (idx_ext),
      .count  (cnt_ext),
      .value  (in_req.value),
      .next_q (nbr),
      .q      (cell_q[i]),
      .rd     (cell_rd[i])
    );
  end

  cpl_reduce #(
    .N (CAPACITY)
  ) u_reduce (
    .clk (clk),
    .rd  (cell_rd),
    .sum (read_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_r        <= accept;
      out_valid_r <= s1_r;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Hold the request's status and length until the read-out is folded
  always_ff @(posedge clk) begin
    if (accept) begin
      get_r    <= ctrl.get_go;
      status_r <= status_nxt;
      length_r <= len_wide[9:0];
    end
    if (s1_r) begin
      out_res_r.read_value <= get_r ? read_sum : 64'd0;
      out_res_r.status     <= status_r;
      out_res_r.length     <= length_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### sv/cpl_cell.sv
// One list cell: holds an entry, loads on append, takes its neighbor on remove.
`timescale 1ns / 1ps
module cpl_cell #(
  parameter int POS = 0,
  parameter int KW  = 10
) (
  input  logic               clk,
  input  cpl_pkg::cell_ctrl_t ctrl,
  input  logic [KW-1:0]      idx,
  input  logic [KW-1:0]      count,
  input  logic [63:0]        value,
  input  logic [63:0]        next_q,
  output logic [63:0]        q,
  output logic [63:0]        rd
);
  import cpl_pkg::*;

  localparam logic [KW-1:0] MY_POS  = KW'(POS);
  localparam logic [KW-1:0] NXT_POS = KW'(POS + 1);

  logic [63:0] entry_r;
  logic [63:0] entry_nxt;
  logic        load;
  logic        shift;

  assign load  = ctrl.append_go && (count == MY_POS);
  assign shift = ctrl.remove_go && (MY_POS >= idx) && (NXT_POS < count);

  always_comb begin
    entry_nxt = entry_r;
    if (load) begin
      entry_nxt = value;
    end else if (shift) begin
      entry_nxt = next_q;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q  = entry_r;
  assign rd = (ctrl.get_go && (idx == MY_POS)) ? entry_r : 64'd0;

endmodule

### sv/cpl_reduce.sv
// Read-out tree: OR the masked cell outputs per group, register, then OR the groups.
`timescale 1ns / 1ps
module cpl_reduce #(
  parameter int N = 512
) (
  input  logic        clk,
  input  logic [63:0] rd [N],
  output logic [63:0] sum
);
  import cpl_pkg::*;

  localparam int NGROUP = (N + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [63:0] group_r   [NGROUP];
  logic [63:0] group_nxt [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      group_nxt[g] = 64'd0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < N) begin
          group_nxt[g] = group_nxt[g] | rd[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    group_r <= group_nxt;
  end

  always_comb begin
    sum = 64'd0;
    for (int g = 0; g < NGROUP; g++) begin
      sum = sum | group_r[g];
    end
  end

endmodule

### sv/cpl_chk.sv
// Port-level checker for the compacting list, bound to the top level.
`timescale 1ns / 1ps
module cpl_chk #(
  parameter int CAPACITY = 512
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input cpl_pkg::out_res_t out_res,
  input logic              out_valid
);
  import cpl_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request accepted but no result two cycles later");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != STATUS_OK) |-> (out_res.read_value == 64'd0))
    else $error("error result carries a nonzero read value");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == STATUS_FULL) |-> (out_res.length == 10'(CAPACITY)))
    else $error("full status reported below capacity");

endmodule

bind compacting_pointer_list cpl_chk #(
  .CAPACITY (CAPACITY)
) u_cpl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_res   (out_res),
  .out_valid (out_valid)
);

### sim/list_checker.sv
// Checker: predicts the compacting list and compares every result against it.
`timescale 1ns / 1ps
module list_checker #(
  parameter int CAPACITY = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  cpl_pkg::in_req_t  in_req,
  input  logic              out_valid,
  input  cpl_pkg::out_res_t out_res,
  output int                fail_count,
  output int                pending,
  output int                list_len
);
  import cpl_pkg::*;

  logic [63:0] list_mem [CAPACITY];
  int          held;
  int          owed;
  int          mismatches;
  int          result_no;
  out_res_t    pending_results [$];

  assign fail_count = mismatches;
  assign pending    = owed;
  assign list_len   = held;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 50)
      $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $time, result_no, what, got, want);
    mismatches++;
  endtask

  // Apply one request to the predicted list and return its result.
  task automatic apply_to_list(input in_req_t r, output out_res_t res);
    res = '0;
    case (r.mode)
      MODE_APPEND: begin
        if (held >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          list_mem[held] = r.value;
          held++;
        end
      end
      MODE_REMOVE: begin
        if (int'(r.index) >= held) begin
          res.status = STATUS_RANGE;
        end else begin
          for (int i = int'(r.index); i + 1 < held; i++)
            list_mem[i] = list_mem[i + 1];
          held--;
        end
      end
      MODE_GET: begin
        if (int'(r.index) >= held)
          res.status = STATUS_RANGE;
        else
          res.read_value = list_mem[r.index];
      end
      default: ;
    endcase
    res.length = held[9:0];
  endtask

  always @(posedge clk) begin
    out_res_t want;
    out_res_t res;
    if (!rst_n) begin
      held = 0;
      pending_results.delete();
      owed = 0;
    end else begin
      // Retire the result first: it always belongs to an earlier request.
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request", out_res.read_value, 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_res.read_value !== want.read_value)
            report_mismatch("read_value", out_res.read_value, want.read_value);
          if (out_res.status !== want.status)
            report_mismatch("status", 64'(out_res.status), 64'(want.status));
          if (out_res.length !== want.length)
            report_mismatch("length", 64'(out_res.length), 64'(want.length));
        end
        result_no++;
      end
      if (start && !busy) begin
        apply_to_list(in_req, res);
        pending_results.push_back(res);
      end
      owed = pending_results.size();
    end
  end

endmodule

### sim/tb.sv
// Testbench top: clock, reset, request stimulus and verdict for the compacting list.
`timescale 1ns / 1ps
module tb;
  import cpl_pkg::*;

  localparam int CAPACITY = 512;
  // Mode 3 has no meaning; the list must ignore it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_res_t out_res;

  int fail_count;
  int pending;
  int list_len;
  int quiet_left;

  compacting_pointer_list #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // The checker owns the predicted list; the top only reads its length, the
  // number of results still owed and the failure count.
  list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Draw the idle time before the next request. Now and then start a stretch
  // of back-to-back requests so the one-cycle busy window gets hammered.
  function automatic int draw_gap();
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      quiet_left = $urandom_range(10, 30);
    return $urandom_range(0, 17);
  endfunction

  // Idle for gap cycles. Called at a falling edge; keep start high when the
  // gap is zero so the next request follows without a bubble.
  task automatic next_slot(int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Present a request, hold it through busy, and return at the falling edge
  // after the accepting rising edge.
  task automatic issue(in_req_t r);
    start  = 1'b1;
    in_req = r;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic directed(logic [1:0] m, logic [8:0] idx, logic [63:0] v);
    in_req_t r;
    next_slot(draw_gap());
    r.mode  = m;
    r.index = idx;
    r.value = v;
    issue(r);
  endtask

  // Random request: append_pct appends, get_pct gets, one percent unused mode,
  // the rest removes. Indexes mostly land inside the current list.
  task automatic random_request(int append_pct, int get_pct);
    in_req_t r;
    int      pick;
    next_slot(draw_gap());
    pick = $urandom_range(0, 99);
    if (pick < append_pct)
      r.mode = MODE_APPEND;
    else if (pick < append_pct + get_pct)
      r.mode = MODE_GET;
    else if (pick < 99)
      r.mode = MODE_REMOVE;
    else
      r.mode = MODE_UNUSED;
    if (list_len > 0 && $urandom_range(0, 3) != 0)
      r.index = 9'($urandom_range(0, list_len - 1));
    else
      r.index = 9'($urandom_range(0, 511));
    r.value = {$urandom, $urandom};
    issue(r);
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic drain_results();
    start = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    quiet_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty list: every indexed request is out of range.
    directed(MODE_GET,    9'd0,   64'd0);
    directed(MODE_REMOVE, 9'd0,   64'd0);
    directed(MODE_GET,    9'd511, '1);
    directed(MODE_REMOVE, 9'd511, '1);
    directed(MODE_UNUSED, 9'd0,   64'd0);

    // Build a short list with extreme and alternating values.
    directed(MODE_APPEND, 9'd0,   64'd0);
    directed(MODE_APPEND, 9'd511, '1);
    directed(MODE_APPEND, 9'd0,   64'hAAAA_AAAA_AAAA_AAAA);
    directed(MODE_APPEND, 9'd0,   64'h5555_5555_5555_5555);
    directed(MODE_GET,    9'd1,   64'd0);
    directed(MODE_GET,    9'd3,   64'd0);
    directed(MODE_GET,    9'd4,   64'd0);
    directed(MODE_REMOVE, 9'd4,   64'd0);

    // Remove from the middle, then check the tail moved down.
    directed(MODE_REMOVE, 9'd1,   64'd0);
    directed(MODE_GET,    9'd1,   64'd0);
    directed(MODE_GET,    9'd2,   64'd0);
    directed(MODE_GET,    9'd3,   64'd0);
    // Remove the last, then the first entry; unused mode must not touch the list.
    directed(MODE_REMOVE, 9'd2,   64'd0);
    directed(MODE_REMOVE, 9'd0,   64'd0);
    directed(MODE_UNUSED, 9'd511, '1);
    directed(MODE_GET,    9'd0,   64'd0);

    // Fill to capacity with random content and a few reads mixed in.
    while (list_len < CAPACITY)
      random_request(97, 2);
    drain_results();

    // Full list: rejected appends, reads at both ends, a full-length shift.
    directed(MODE_APPEND, 9'd0,   {$urandom, $urandom});
    directed(MODE_APPEND, 9'd0,   '1);
    directed(MODE_GET,    9'd511, 64'd0);
    directed(MODE_GET,    9'd0,   64'd0);
    directed(MODE_REMOVE, 9'd0,   64'd0);
    directed(MODE_GET,    9'd0,   64'd0);
    directed(MODE_GET,    9'd511, 64'd0);
    directed(MODE_APPEND, 9'd0,   {$urandom, $urandom});
    directed(MODE_REMOVE, 9'd511, 64'd0);
    directed(MODE_APPEND, 9'd0,   {$urandom, $urandom});
    directed(MODE_APPEND, 9'd0,   {$urandom, $urandom});

    // Drain-heavy traffic, then a balanced mix.
    repeat (12) random_request(20, 30);
    drain_results();
    repeat (12) random_request(45, 30);

    drain_results();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
